[src/shell_quote_tokenizer_top_assert.svh]
// Assertion macros for the tokenizer, clocked on clk, disabled in reset.
`ifndef SHELL_QUOTE_TOKENIZER_TOP_ASSERT_SVH
`define SHELL_QUOTE_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SQT_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SQT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sqt_pkg.sv]
`default_nettype none

package sqt_pkg;

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_WORD_END = 2'd1,
        KIND_LINE_END = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } quote_t;

    localparam logic CMD_CHAR     = 1'b0;
    localparam logic CMD_LINE_END = 1'b1;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_BACKQUOTE = 8'h60;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_NONE      = 8'h00;

    typedef struct packed {
        logic       command;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_char;
        quote_t     open_quote;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

[src/shell_quote_tokenizer_top.sv]
// A result is registered and shown in the cycle after its item transfer.
// Throughput: one item per cycle when unstalled; an item with two results
// holds the input while the second result drains from the output slots.
// Reset (rst_n low, asynchronous): quote, escape and word flags clear and
// both output slots empty.
`default_nettype none

module shell_quote_tokenizer_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire sqt_pkg::item_t  item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output sqt_pkg::result_t     result
);
    import sqt_pkg::*;

    logic       sq_reg, sq_next;
    logic       dq_reg, dq_next;
    logic       esc_reg, esc_next;
    logic       whc_reg, whc_next;
    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;

    result_t    res0;
    result_t    res1;
    logic [1:0] n_res;
    logic       item_fire;
    logic       result_fire;

    assign result_valid = (cnt_reg != 2'd0);
    assign result       = slot0_reg;
    assign result_fire  = result_valid && !result_stall;
    assign item_stall   = !((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !result_stall));
    assign item_fire    = item_valid && !item_stall;

    always_comb
    begin
        sq_next  = sq_reg;
        dq_next  = dq_reg;
        esc_next = esc_reg;
        whc_next = whc_reg;
        n_res    = 2'd0;
        res0     = '{kind: KIND_CHAR, out_char: CH_NONE, open_quote: QUOTE_NONE, last: 1'b0};
        res1     = '{kind: KIND_CHAR, out_char: CH_NONE, open_quote: QUOTE_NONE, last: 1'b1};
        if (item.command == CMD_LINE_END)
        begin
            if (whc_reg)
            begin
                res0.kind       = KIND_WORD_END;
                res0.open_quote = sq_reg ? QUOTE_SINGLE : (dq_reg ? QUOTE_DOUBLE : QUOTE_NONE);
                res1.kind       = KIND_LINE_END;
                n_res           = 2'd2;
            end
            else
            begin
                res0.kind = KIND_LINE_END;
                n_res     = 2'd1;
            end
            sq_next  = 1'b0;
            dq_next  = 1'b0;
            esc_next = 1'b0;
            whc_next = 1'b0;
        end
        else
        begin
            case (item.ch)
                CH_SPACE:
                begin
                    if (whc_reg)
                    begin
                        n_res = 2'd1;
                        if (!sq_reg && !dq_reg && !esc_reg)
                        begin
                            res0.kind = KIND_WORD_END;
                            whc_next  = 1'b0;
                        end
                        else
                        begin
                            res0.out_char = CH_SPACE;
                            esc_next      = 1'b0;
                        end
                    end
                end
                CH_BACKSLASH:
                begin
                    res0.out_char = CH_BACKSLASH;
                    if (sq_reg)
                    begin
                        n_res    = 2'd1;
                        whc_next = 1'b1;
                    end
                    else
                    begin
                        if (esc_reg)
                        begin
                            n_res    = 2'd1;
                            whc_next = 1'b1;
                        end
                        esc_next = !esc_reg;
                    end
                end
                CH_SQUOTE:
                begin
                    if (dq_reg)
                    begin
                        whc_next = 1'b1;
                        esc_next = 1'b0;
                        if (esc_reg)
                        begin
                            res0.out_char = CH_BACKSLASH;
                            res1.out_char = CH_SQUOTE;
                            n_res         = 2'd2;
                        end
                        else
                        begin
                            res0.out_char = CH_SQUOTE;
                            n_res         = 2'd1;
                        end
                    end
                    else if (esc_reg)
                    begin
                        esc_next      = 1'b0;
                        whc_next      = 1'b1;
                        res0.out_char = CH_SQUOTE;
                        n_res         = 2'd1;
                    end
                    else
                    begin
                        sq_next = !sq_reg;
                    end
                end
                CH_DQUOTE:
                begin
                    if (sq_reg || esc_reg)
                    begin
                        esc_next      = sq_reg ? esc_reg : 1'b0;
                        whc_next      = 1'b1;
                        res0.out_char = CH_DQUOTE;
                        n_res         = 2'd1;
                    end
                    else
                    begin
                        dq_next = !dq_reg;
                    end
                end
                default:
                begin
                    whc_next = 1'b1;
                    esc_next = 1'b0;
                    if (esc_reg && dq_reg && (item.ch != CH_DOLLAR)
                        && (item.ch != CH_BACKQUOTE))
                    begin
                        res0.out_char = CH_BACKSLASH;
                        res1.out_char = item.ch;
                        n_res         = 2'd2;
                    end
                    else
                    begin
                        res0.out_char = item.ch;
                        n_res         = 2'd1;
                    end
                end
            endcase
        end
        res0.last = (n_res == 2'd1);
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (result_fire)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (item_fire)
        begin
            slot0_next = res0;
            slot1_next = res1;
            cnt_next   = n_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg  <= 1'b0;
            dq_reg  <= 1'b0;
            esc_reg <= 1'b0;
            whc_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (item_fire)
            begin
                sq_reg  <= sq_next;
                dq_reg  <= dq_next;
                esc_reg <= esc_next;
                whc_reg <= whc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

`include "shell_quote_tokenizer_top_assert.svh"

    `SQT_ASSERT(a_cnt_range, 1'b1, cnt_reg != 2'd3, "output slot count out of range")
    `SQT_ASSERT(a_first_not_last, cnt_reg == 2'd2, !slot0_reg.last && slot1_reg.last,
        "first of two results marked last")
    `SQT_ASSERT(a_line_end_last, result_valid && (result.kind == KIND_LINE_END),
        result.last, "line end not marked last")
    `SQT_ASSERT(a_quote_on_word_end, result_valid && (result.open_quote != QUOTE_NONE),
        result.kind == KIND_WORD_END, "open quote reported outside word end")
    `SQT_ASSERT_NEXT(a_eol_clears, item_fire && (item.command == CMD_LINE_END),
        !sq_reg && !dq_reg && !esc_reg && !whc_reg, "state not cleared after line end")

endmodule

`default_nettype wire
